### src/utf8wc_pkg.sv
// Package for the UTF-8 word counter: word types, byte codes and widths.
// Used by utf8wc_classify, utf8wc_core and utf8_word_counter; depends on nothing.
package utf8wc_pkg;

    // Width of the reported word total and default width of the internal counter.
    localparam int unsigned TotalBits     = 32;
    localparam int unsigned CountBitsDef  = 32;

    // Lead byte masks and patterns.
    localparam logic [7:0] MaskLead2 = 8'hE0;
    localparam logic [7:0] PatLead2  = 8'hC0;
    localparam logic [7:0] MaskLead3 = 8'hF0;
    localparam logic [7:0] PatLead3  = 8'hE0;
    localparam logic [7:0] MaskLead4 = 8'hF8;
    localparam logic [7:0] PatLead4  = 8'hF0;
    localparam logic [7:0] MaskCont  = 8'hC0;
    localparam logic [7:0] PatCont   = 8'h80;

    // Character length minus one.
    localparam logic [1:0] Len1Byte = 2'd0;
    localparam logic [1:0] Len2Byte = 2'd1;
    localparam logic [1:0] Len3Byte = 2'd2;
    localparam logic [1:0] Len4Byte = 2'd3;

    // Multibyte delimiter bytes.
    localparam logic [7:0] LeadC2      = 8'hC2;
    localparam logic [7:0] GuilOpen    = 8'hAB;
    localparam logic [7:0] GuilClose   = 8'hBB;
    localparam logic [7:0] LeadE2      = 8'hE2;
    localparam logic [7:0] Punct80     = 8'h80;
    localparam logic [7:0] QuoteOpen   = 8'h9C;
    localparam logic [7:0] QuoteClose  = 8'h9D;
    localparam logic [7:0] EnDash      = 8'h93;
    localparam logic [7:0] Ellipsis    = 8'hA6;

    // One input word: a text byte and the end-of-text mark.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } t_in_word;

    // One result word.
    typedef struct packed {
        logic [TotalBits-1:0] word_total;
        logic                 inside_word;
        logic                 corrupt;
    } t_out_word;

endpackage

### src/utf8wc_classify.sv
// Delimiter classifier for one complete UTF-8 character.
// Depends on utf8wc_pkg for the character codes.
module utf8wc_classify
    import utf8wc_pkg::*;
(
    input  logic [1:0] i_len1,
    input  logic [7:0] i_first,
    input  logic [7:0] i_second,
    input  logic [7:0] i_last,
    output logic       o_delim
);

    logic ascii_delim;

    // ASCII whitespace and punctuation that separate words.
    always_comb begin
        case (i_last)
            8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2D, 8'h22, 8'h5B, 8'h5D,
            8'h28, 8'h29, 8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h3F, 8'h21: begin
                ascii_delim = 1'b1;
            end
            default: begin
                ascii_delim = 1'b0;
            end
        endcase
    end

    // Select the rule that matches the character length.
    always_comb begin
        unique case (i_len1)
            Len1Byte: begin
                o_delim = ascii_delim;
            end
            Len2Byte: begin
                o_delim = (i_first == LeadC2) &&
                          ((i_last == GuilOpen) || (i_last == GuilClose));
            end
            Len3Byte: begin
                o_delim = (i_first == LeadE2) && (i_second == Punct80) &&
                          ((i_last == QuoteOpen) || (i_last == QuoteClose) ||
                           (i_last == EnDash) || (i_last == Ellipsis));
            end
            default: begin
                o_delim = 1'b0;
            end
        endcase
    end

endmodule

### src/utf8wc_core.sv
// Character assembly, word tracking and saturating word counter.
// Depends on utf8wc_pkg and utf8wc_classify.
module utf8wc_core
    import utf8wc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = CountBitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    logic                  r_word_flag, n_word_flag;
    logic [1:0]            r_bytes_rem, n_bytes_rem;
    logic [1:0]            r_seq_len, n_seq_len;
    logic [7:0]            r_first, n_first;
    logic [7:0]            r_second, n_second;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_error, n_error;

    logic       cls_go;
    logic [1:0] cls_len1;
    logic [7:0] cls_first;
    logic       cls_delim;
    logic       flag_mid;
    logic       eot_ok;
    logic       inc;
    logic [7:0] b;

    assign b = i_word.data_byte;

    utf8wc_classify u_classify (
        .i_len1   (cls_len1),
        .i_first  (cls_first),
        .i_second (r_second),
        .i_last   (b),
        .o_delim  (cls_delim)
    );

    // Next state for one byte.
    always_comb begin
        n_bytes_rem = r_bytes_rem;
        n_seq_len   = r_seq_len;
        n_first     = r_first;
        n_second    = r_second;
        n_error     = r_error;
        cls_go      = 1'b0;
        cls_len1    = Len1Byte;
        cls_first   = b;
        flag_mid    = r_word_flag;
        if (!r_error) begin
            if (r_bytes_rem == 2'd0) begin
                if (!b[7]) begin
                    cls_go = 1'b1;
                end else if ((b & MaskLead2) == PatLead2) begin
                    n_first     = b;
                    n_seq_len   = Len2Byte;
                    n_bytes_rem = Len2Byte;
                end else if ((b & MaskLead3) == PatLead3) begin
                    n_first     = b;
                    n_seq_len   = Len3Byte;
                    n_bytes_rem = Len3Byte;
                end else if ((b & MaskLead4) == PatLead4) begin
                    n_first     = b;
                    n_seq_len   = Len4Byte;
                    n_bytes_rem = Len4Byte;
                end else begin
                    // A stray byte is a one-byte word character.
                    flag_mid = 1'b1;
                end
            end else if ((b & MaskCont) != PatCont) begin
                n_error = 1'b1;
            end else begin
                if (r_bytes_rem == r_seq_len) begin
                    n_second = b;
                end
                n_bytes_rem = r_bytes_rem - 2'd1;
                if (r_bytes_rem == 2'd1) begin
                    cls_go    = 1'b1;
                    cls_len1  = r_seq_len;
                    cls_first = r_first;
                end
            end
        end
        if (cls_go) begin
            flag_mid = !cls_delim;
        end
        // End of text drops a partial character and closes an open word.
        eot_ok = i_word.end_of_text && !n_error;
        if (eot_ok) begin
            n_bytes_rem = 2'd0;
        end
        inc         = (cls_go && cls_delim && r_word_flag) || (eot_ok && flag_mid);
        n_word_flag = eot_ok ? 1'b0 : flag_mid;
        n_count     = (inc && (r_count != '1)) ? r_count + COUNT_BITS'(1) : r_count;
    end

    // Result for this byte, total clamped to the reported width.
    generate
        if (COUNT_BITS > TotalBits) begin : g_clamp
            assign o_result.word_total = (|n_count[COUNT_BITS-1:TotalBits]) ?
                                         '1 : n_count[TotalBits-1:0];
        end else begin : g_extend
            assign o_result.word_total = TotalBits'(n_count);
        end
    endgenerate
    assign o_result.inside_word = flag_mid;
    assign o_result.corrupt     = n_error;

    // State registers, updated once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_flag <= 1'b0;
            r_bytes_rem <= 2'd0;
            r_seq_len   <= 2'd0;
            r_first     <= 8'd0;
            r_second    <= 8'd0;
            r_count     <= '0;
            r_error     <= 1'b0;
        end else if (i_en) begin
            r_word_flag <= n_word_flag;
            r_bytes_rem <= n_bytes_rem;
            r_seq_len   <= n_seq_len;
            r_first     <= n_first;
            r_second    <= n_second;
            r_count     <= n_count;
            r_error     <= n_error;
        end
    end

    // The corrupt flag is sticky.
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |=> r_error)
        else $error("corrupt flag cleared");

    // Counting is frozen once the text is corrupt.
    a_error_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_error |=> $stable(r_count))
        else $error("counter moved after corruption");

    // The counter never goes backward.
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count >= $past(r_count)))
        else $error("counter decreased");

    // Pending continuation bytes never exceed the character length.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_rem <= r_seq_len)
        else $error("continuation count out of range");

endmodule

### src/utf8_word_counter.sv
// Top level of the UTF-8 word counter: input register, core and result register.
// Depends on utf8wc_pkg and utf8wc_core.
//
// Usage:
//   The input channel (i_in_valid, o_in_ready, i_in_word) takes one word per
//   cycle while o_in_ready is high: a text byte and an end-of-text mark on
//   its final byte. The output channel (o_out_valid, i_out_ready, o_out_word)
//   returns one result word per input word: the saturating word total,
//   whether the current character is in a word, and the sticky corrupt flag.
//   Each accepted byte passes the input register and then the result register
//   before its result shows on o_out_valid. Throughput is one byte per cycle
//   while the receiver takes results; the character decode, delimiter compare
//   and counter increment sit between the input and result registers.
//   A synchronous active-low reset empties both registers and clears the
//   counter, the word state and the corrupt flag; the total is kept across
//   texts until the next reset.
//   When the receiver stalls, the result register holds its word and the
//   input register still accepts one more word, after which o_in_ready drops
//   until the result is taken.
module utf8_word_counter
    import utf8wc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = CountBitsDef
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word core_result;
    logic      advance;

    // A byte moves to the result register when that register is free or drains.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    utf8wc_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_word   (r_in_word),
        .o_result (core_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= core_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // With no result waiting, the input side is always open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input blocked with empty result register");

    // A byte held in the input register always yields a result next cycle
    // unless the result register is stalled.
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed byte produced no result");

endmodule

### dv/utf8_word_counter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_word_counter: a predictor of the word total,
// the in-word state and the corrupt flag is checked against every result word.
// Depends on utf8wc_pkg and the RTL of utf8_word_counter.
module utf8_word_counter_tb;
    import utf8wc_pkg::*;

    localparam int unsigned ResetCycles     = 5;
    localparam int unsigned TimeoutCycles   = 200000;
    localparam int unsigned DrainCycles     = 8;
    localparam int unsigned TextBytesTarget = 1035;
    localparam int unsigned MaxReports      = 10;
    localparam int unsigned HoldStartFirst  = 600;
    localparam int unsigned HoldStartSecond = 1500;
    localparam int unsigned HoldCycles      = 150;

    // Single-byte delimiters: space, tab, LF, CR, - " [ ] ( ) . , : ; ? !
    localparam logic [7:0] AsciiDelims [16] = '{
        8'h20, 8'h09, 8'h0A, 8'h0D, 8'h2D, 8'h22, 8'h5B, 8'h5D,
        8'h28, 8'h29, 8'h2E, 8'h2C, 8'h3A, 8'h3B, 8'h3F, 8'h21
    };

    // Receiver behavior for one stretch of cycles.
    typedef enum logic [1:0] {
        RxFree,
        RxHalf,
        RxMost,
        RxOneInFour
    } t_rx_mode;

    // Predicts the result of each accepted byte and checks the results in order.
    class utf8_total_tracker;
        bit                    open_word;
        bit [1:0]              cont_left;
        bit [1:0]              char_len1;
        bit [7:0]              lead_byte;
        bit [7:0]              second_byte;
        bit [CountBitsDef-1:0] total_so_far;
        bit                    corrupt_seen;
        t_out_word             expected_totals[$];
        int unsigned           mismatches;
        int unsigned           results_checked;

        function int unsigned pending();
            return expected_totals.size();
        endfunction

        // Count an open word, holding at the counter maximum.
        function void close_word();
            if (open_word) begin
                if (total_so_far != '1) begin
                    total_so_far = total_so_far + 1'b1;
                end
                open_word = 1'b0;
            end
        endfunction

        function bit is_ascii_delim(bit [7:0] b);
            bit hit;
            hit = 1'b0;
            foreach (AsciiDelims[i]) begin
                if (AsciiDelims[i] == b) begin
                    hit = 1'b1;
                end
            end
            return hit;
        endfunction

        // A completed character either ends the open word or belongs to one.
        function void finish_char(bit [1:0] len1, bit [7:0] b0, bit [7:0] b1, bit [7:0] last);
            bit delim;
            delim = 1'b0;
            case (len1)
                Len1Byte: begin
                    delim = is_ascii_delim(b0);
                end
                Len2Byte: begin
                    delim = (b0 == LeadC2) && (last == GuilOpen || last == GuilClose);
                end
                Len3Byte: begin
                    delim = (b0 == LeadE2) && (b1 == Punct80) &&
                            (last == QuoteOpen || last == QuoteClose ||
                             last == EnDash || last == Ellipsis);
                end
                default: begin
                    delim = 1'b0;
                end
            endcase
            if (delim) begin
                close_word();
            end else begin
                open_word = 1'b1;
            end
        endfunction

        function void note_byte(t_in_word w);
            t_out_word expected;
            bit [1:0]  len1;
            bit        shown;
            if (!corrupt_seen) begin
                if (cont_left == 2'd0) begin
                    // Decode the lead byte; anything else is a stray one-byte character.
                    if (w.data_byte[7] == 1'b0) begin
                        len1 = Len1Byte;
                    end else if ((w.data_byte & MaskLead2) == PatLead2) begin
                        len1 = Len2Byte;
                    end else if ((w.data_byte & MaskLead3) == PatLead3) begin
                        len1 = Len3Byte;
                    end else if ((w.data_byte & MaskLead4) == PatLead4) begin
                        len1 = Len4Byte;
                    end else begin
                        len1 = Len1Byte;
                    end
                    if (len1 == Len1Byte) begin
                        if (w.data_byte[7]) begin
                            open_word = 1'b1;
                        end else begin
                            finish_char(Len1Byte, w.data_byte, 8'h00, w.data_byte);
                        end
                    end else begin
                        lead_byte = w.data_byte;
                        char_len1 = len1;
                        cont_left = len1;
                    end
                end else if ((w.data_byte & MaskCont) != PatCont) begin
                    corrupt_seen = 1'b1;
                end else begin
                    if (cont_left == char_len1) begin
                        second_byte = w.data_byte;
                    end
                    cont_left = cont_left - 2'd1;
                    if (cont_left == 2'd0) begin
                        finish_char(char_len1, lead_byte, second_byte, w.data_byte);
                    end
                end
                shown = open_word;
                // End of text drops a partial character and counts an open word.
                if (w.end_of_text && !corrupt_seen) begin
                    cont_left = 2'd0;
                    close_word();
                end
            end else begin
                shown = open_word;
            end
            if (total_so_far > {TotalBits{1'b1}}) begin
                expected.word_total = '1;
            end else begin
                expected.word_total = total_so_far[TotalBits-1:0];
            end
            expected.inside_word = shown;
            expected.corrupt     = corrupt_seen;
            expected_totals.push_back(expected);
        endfunction

        function void report(string what, t_out_word want, t_out_word got);
            mismatches++;
            if (mismatches <= MaxReports) begin
                $display("%s: expected total %0d inside %0b corrupt %0b, got total %0d inside %0b corrupt %0b",
                         what, want.word_total, want.inside_word, want.corrupt,
                         got.word_total, got.inside_word, got.corrupt);
            end
        endfunction

        function void check_total(t_out_word got);
            t_out_word want;
            if (expected_totals.size() == 0) begin
                report("Result word with no byte pending", '0, got);
            end else begin
                want = expected_totals.pop_front();
                if (got.word_total !== want.word_total ||
                    got.inside_word !== want.inside_word ||
                    got.corrupt !== want.corrupt) begin
                    report($sformatf("Mismatch on result %0d", results_checked), want, got);
                end
                results_checked++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      o_in_ready;
    t_in_word  in_word;
    logic      o_out_valid;
    logic      out_ready;
    t_out_word o_out_word;

    t_in_word          text_bytes[$];
    utf8_total_tracker tracker = new;
    int unsigned       cycle_count;
    int unsigned       in_stall_cycles;

    utf8_word_counter DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_word (o_out_word)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic bit [7:0] cont_byte();
        return PatCont | 8'($urandom_range(0, 63));
    endfunction

    function automatic void push_byte(bit [7:0] b, bit eot);
        t_in_word w;
        w.data_byte   = b;
        w.end_of_text = eot;
        text_bytes.push_back(w);
    endfunction

    // Short text touching every delimiter form, stray bytes and both flush cases.
    task automatic add_directed_text();
        push_byte(8'h61, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(LeadC2, 1'b0);
        push_byte(GuilOpen, 1'b0);
        push_byte(LeadE2, 1'b0);
        push_byte(Punct80, 1'b0);
        push_byte(QuoteOpen, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'hA9, 1'b0);
        push_byte(LeadE2, 1'b0);
        push_byte(Punct80, 1'b0);
        push_byte(EnDash, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h9F, 1'b0);
        push_byte(8'h98, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(LeadC2, 1'b0);
        push_byte(GuilClose, 1'b0);
        push_byte(8'h7A, 1'b1);
        push_byte(8'hE3, 1'b1);
        push_byte(8'h2E, 1'b0);
    endtask

    // One random character, mostly well formed, sometimes stray or cut short.
    task automatic add_random_char();
        bit [7:0]    seq[$];
        int unsigned pick;
        int unsigned need;
        int unsigned kept;
        bit          eot;
        pick = $urandom_range(0, 99);
        eot  = ($urandom_range(0, 29) == 0);
        if (pick < 35) begin
            case ($urandom_range(0, 2))
                0:       seq.push_back(8'(8'h61 + $urandom_range(0, 25)));
                1:       seq.push_back(8'(8'h41 + $urandom_range(0, 25)));
                default: seq.push_back(8'(8'h30 + $urandom_range(0, 9)));
            endcase
        end else if (pick < 55) begin
            seq.push_back(AsciiDelims[$urandom_range(0, 15)]);
        end else if (pick < 63) begin
            seq.push_back(8'($urandom_range(0, 127)));
        end else if (pick < 71) begin
            seq.push_back(PatLead2 | 8'($urandom_range(0, 31)));
            seq.push_back(cont_byte());
        end else if (pick < 77) begin
            seq.push_back(LeadC2);
            case ($urandom_range(0, 3))
                0, 1:    seq.push_back(GuilOpen);
                2:       seq.push_back(GuilClose);
                default: seq.push_back(cont_byte());
            endcase
        end else if (pick < 85) begin
            seq.push_back(LeadE2);
            seq.push_back(Punct80);
            case ($urandom_range(0, 3))
                0:       seq.push_back(QuoteOpen);
                1:       seq.push_back(QuoteClose);
                2:       seq.push_back(EnDash);
                default: seq.push_back(Ellipsis);
            endcase
        end else if (pick < 89) begin
            // Near misses of the three-byte delimiters and random three-byte characters.
            if ($urandom_range(0, 1) == 0) begin
                seq.push_back(LeadE2);
            end else begin
                seq.push_back(PatLead3 | 8'($urandom_range(0, 15)));
            end
            seq.push_back(cont_byte());
            seq.push_back(cont_byte());
        end else if (pick < 94) begin
            seq.push_back(PatLead4 | 8'($urandom_range(0, 7)));
            seq.push_back(cont_byte());
            seq.push_back(cont_byte());
            seq.push_back(cont_byte());
        end else if (pick < 98) begin
            if ($urandom_range(0, 1) == 0) begin
                seq.push_back(cont_byte());
            end else begin
                seq.push_back(8'hF8 | 8'($urandom_range(0, 7)));
            end
        end else begin
            // Character cut short by the end of the text.
            need = $urandom_range(1, 3);
            case (need)
                1:       seq.push_back(PatLead2 | 8'($urandom_range(0, 31)));
                2:       seq.push_back(PatLead3 | 8'($urandom_range(0, 15)));
                default: seq.push_back(PatLead4 | 8'($urandom_range(0, 7)));
            endcase
            kept = $urandom_range(0, need - 1);
            repeat (kept) seq.push_back(cont_byte());
            eot = 1'b1;
        end
        foreach (seq[i]) begin
            push_byte(seq[i], eot && (i == seq.size() - 1));
        end
    endtask

    // A bad continuation byte freezes the block, so it comes last.
    task automatic add_corrupt_tail();
        push_byte(8'h61, 1'b0);
        push_byte(8'hC5, 1'b0);
        push_byte(8'h41, 1'b1);
        repeat (12) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    task automatic offer_word(t_in_word w);
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic pause_input(int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    task automatic send_text();
        int unsigned idx;
        int unsigned burst;
        idx = 0;
        while (idx < text_bytes.size()) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 25);
            while (burst != 0 && idx < text_bytes.size()) begin
                offer_word(text_bytes[idx]);
                idx++;
                burst--;
            end
            pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
    endtask

    // Receiver: stall pattern changes per stretch, with long hold-offs to fill the block.
    initial begin
        int unsigned rx_cycle;
        int unsigned hold_left;
        int unsigned mode_left;
        t_rx_mode    mode;
        out_ready = 1'b0;
        rx_cycle  = 0;
        hold_left = 0;
        mode_left = 0;
        mode      = RxFree;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == HoldStartFirst || rx_cycle == HoldStartSecond) begin
                hold_left = HoldCycles;
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 250);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                case (mode)
                    RxFree:      out_ready <= 1'b1;
                    RxHalf:      out_ready <= ($urandom_range(0, 1) == 0);
                    RxMost:      out_ready <= ($urandom_range(0, 3) != 0);
                    default:     out_ready <= (rx_cycle % 4 == 0);
                endcase
            end
        end
    end

    // Handshake monitor on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                tracker.note_byte(in_word);
            end
            if (in_valid && !o_in_ready) begin
                in_stall_cycles++;
            end
            if (o_out_valid && out_ready) begin
                tracker.check_total(o_out_word);
            end
        end
    end

    // Run limit.
    initial begin
        cycle_count = 0;
        while (cycle_count < TimeoutCycles) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results pending",
                 cycle_count, tracker.pending());
        $display("FAILURE");
        $finish;
    end

    initial begin
        in_valid        = 1'b0;
        in_word         = '0;
        i_rst_n         = 1'b0;
        in_stall_cycles = 0;
        add_directed_text();
        while (text_bytes.size() < TextBytesTarget) add_random_char();
        add_corrupt_tail();
        repeat (ResetCycles) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_text();
        @(negedge i_clk);
        in_valid <= 1'b0;

        // Drain the outstanding results, then give stray outputs a chance to show.
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("Sent %0d text bytes: every delimiter form, stray and truncated characters, %0s",
                 text_bytes.size(), "end-of-text flushes and a frozen corrupt tail.");
        $display("Checked %0d results, final word total %0d, input stalled on %0d cycles.",
                 tracker.results_checked, tracker.total_so_far, in_stall_cycles);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
